/* rtl/bcrs_pkg.sv */
package bcrs_pkg;

  localparam int NumRangesDef = 3;
  localparam int ColW         = 16;
  localparam int ByteW        = 8;
  localparam int CfgIdxW      = 4;
  localparam int CfgDataW     = 16;

  localparam logic [ColW-1:0]  ColMax     = '1;
  localparam logic [ColW-1:0]  RangeLoRst = ColW'(1);
  localparam logic [ColW-1:0]  RangeHiRst = '0;
  localparam logic [ByteW-1:0] NewlineChr = 8'h0A;
  localparam logic [ByteW-1:0] NulChr     = 8'h00;

  // Register map: range k low at RegRangeBase + 2k, high one above it.
  localparam logic [CfgIdxW-1:0] RegRangeBase = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegGapMarker = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] RegModeBits  = CfgIdxW'(7);

  localparam int GapEnBit      = 8;
  localparam int ModeCompBit   = 0;
  localparam int ModeNulTermBit = 1;

  typedef struct packed {
    logic             gap_en;
    logic [ByteW-1:0] gap_byte;
    logic             complement;
    logic             nul_term;
  } cfg_misc_t;

  typedef struct packed {
    logic             first_valid;
    logic [ByteW-1:0] first_byte;
    logic             first_last;
    logic             second_valid;
    logic [ByteW-1:0] second_byte;
  } result_t;

  typedef struct packed {
    logic cur_valid;
    logic extra_valid;
  } out_stat_t;

endpackage

/* rtl/bcrs_if.sv */
interface bcrs_in_if;
  import bcrs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface bcrs_out_if;
  import bcrs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             run_last;
  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

interface bcrs_cfg_if;
  import bcrs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/bcrs_cfg.sv */
module bcrs_cfg #(
  parameter int NUM_RANGES = bcrs_pkg::NumRangesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bcrs_cfg_if.sink             cfg_i,
  output logic [bcrs_pkg::ColW-1:0] range_lo_o [NUM_RANGES],
  output logic [bcrs_pkg::ColW-1:0] range_hi_o [NUM_RANGES],
  output bcrs_pkg::cfg_misc_t  misc_o
);
  import bcrs_pkg::*;

  logic            wr;
  logic [ColW-1:0] range_lo_q [NUM_RANGES];
  logic [ColW-1:0] range_hi_q [NUM_RANGES];
  cfg_misc_t       misc_q;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid;

  for (genvar k = 0; k < NUM_RANGES; k++) begin : g_range
    localparam logic [CfgIdxW-1:0] LoIdx = RegRangeBase + CfgIdxW'(2 * k);
    localparam logic [CfgIdxW-1:0] HiIdx = RegRangeBase + CfgIdxW'(2 * k + 1);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        range_lo_q[k] <= RangeLoRst;
        range_hi_q[k] <= RangeHiRst;
      end else if (wr) begin
        if (cfg_i.index == LoIdx) range_lo_q[k] <= cfg_i.data[ColW-1:0];
        if (cfg_i.index == HiIdx) range_hi_q[k] <= cfg_i.data[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      misc_q <= '0;
    end else if (wr) begin
      if (cfg_i.index == RegGapMarker) begin
        misc_q.gap_en   <= cfg_i.data[GapEnBit];
        misc_q.gap_byte <= cfg_i.data[ByteW-1:0];
      end
      if (cfg_i.index == RegModeBits) begin
        misc_q.complement <= cfg_i.data[ModeCompBit];
        misc_q.nul_term   <= cfg_i.data[ModeNulTermBit];
      end
    end
  end

  assign range_lo_o = range_lo_q;
  assign range_hi_o = range_hi_q;
  assign misc_o     = misc_q;

endmodule

/* rtl/bcrs_select.sv */
module bcrs_select #(
  parameter int NUM_RANGES = bcrs_pkg::NumRangesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [bcrs_pkg::ByteW-1:0] in_byte_i,
  input  logic [bcrs_pkg::ColW-1:0]  range_lo_i [NUM_RANGES],
  input  logic [bcrs_pkg::ColW-1:0]  range_hi_i [NUM_RANGES],
  input  bcrs_pkg::cfg_misc_t        misc_i,
  output bcrs_pkg::result_t          res_o
);
  import bcrs_pkg::*;

  logic [ColW-1:0] col_q, col_d, col_next;
  logic            prev_sel_q, prev_sel_d;
  logic            line_start_q, line_start_d;
  logic            is_nl, hit, sel, delim;

  assign is_nl    = (in_byte_i == NewlineChr);
  // Saturate so an open-ended range still covers very long lines.
  assign col_next = (col_q == ColMax) ? col_q : col_q + ColW'(1);

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NUM_RANGES; k++) begin
      if (range_lo_i[k] <= col_next && col_next <= range_hi_i[k]) hit = 1'b1;
    end
  end

  assign sel   = hit ^ misc_i.complement;
  assign delim = !prev_sel_q && !line_start_q && misc_i.gap_en;

  always_comb begin
    res_o        = '0;
    col_d        = col_q;
    prev_sel_d   = prev_sel_q;
    line_start_d = line_start_q;
    if (is_nl) begin
      res_o.first_valid = 1'b1;
      res_o.first_byte  = misc_i.nul_term ? NulChr : NewlineChr;
      res_o.first_last  = 1'b1;
      col_d             = '0;
      prev_sel_d        = 1'b0;
      line_start_d      = 1'b1;
    end else begin
      col_d      = col_next;
      prev_sel_d = sel;
      if (sel) begin
        line_start_d      = 1'b0;
        res_o.first_valid = 1'b1;
        if (delim) begin
          res_o.first_byte   = misc_i.gap_byte;
          res_o.first_last   = 1'b0;
          res_o.second_valid = 1'b1;
          res_o.second_byte  = in_byte_i;
        end else begin
          res_o.first_byte = in_byte_i;
          res_o.first_last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      prev_sel_q   <= 1'b0;
      line_start_q <= 1'b1;
    end else if (fire_i) begin
      col_q        <= col_d;
      prev_sel_q   <= prev_sel_d;
      line_start_q <= line_start_d;
    end
  end

endmodule

/* rtl/bcrs_out.sv */
module bcrs_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  bcrs_pkg::result_t   res_i,
  output logic                in_ready_o,
  output bcrs_pkg::out_stat_t stat_o,
  bcrs_out_if.source          out_o
);
  import bcrs_pkg::*;

  logic             cur_valid_q, cur_valid_d;
  logic [ByteW-1:0] cur_byte_q, cur_byte_d;
  logic             cur_last_q, cur_last_d;
  logic             extra_valid_q, extra_valid_d;
  logic [ByteW-1:0] extra_byte_q, extra_byte_d;
  logic             out_fire;

  assign out_fire   = cur_valid_q && out_o.ready;
  // Take a new byte once the held beat leaves and no second beat waits behind it.
  assign in_ready_o = !cur_valid_q || (out_o.ready && !extra_valid_q);

  always_comb begin
    cur_valid_d   = cur_valid_q;
    cur_byte_d    = cur_byte_q;
    cur_last_d    = cur_last_q;
    extra_valid_d = extra_valid_q;
    extra_byte_d  = extra_byte_q;
    if (in_fire_i) begin
      cur_valid_d   = res_i.first_valid;
      cur_byte_d    = res_i.first_byte;
      cur_last_d    = res_i.first_last;
      extra_valid_d = res_i.second_valid;
      extra_byte_d  = res_i.second_byte;
    end else if (out_fire) begin
      if (extra_valid_q) begin
        cur_byte_d    = extra_byte_q;
        cur_last_d    = 1'b1;
        extra_valid_d = 1'b0;
      end else begin
        cur_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q   <= 1'b0;
      extra_valid_q <= 1'b0;
    end else begin
      cur_valid_q   <= cur_valid_d;
      extra_valid_q <= extra_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_byte_q   <= cur_byte_d;
    cur_last_q   <= cur_last_d;
    extra_byte_q <= extra_byte_d;
  end

  assign out_o.valid    = cur_valid_q;
  assign out_o.out_byte = cur_byte_q;
  assign out_o.run_last = cur_last_q;

  assign stat_o.cur_valid   = cur_valid_q;
  assign stat_o.extra_valid = extra_valid_q;

endmodule

/* rtl/byte_column_range_selector_top.sv */
// Channel | Dir | Payload               | Beat
// in_i    | in  | in_byte[7:0]          | one text byte
// out_o   | out | out_byte[7:0]         | delimiter, selected byte or terminator
//         |     | run_last              | high on the last beat for a text byte
// cfg_i   | in  | index[3:0], data[15:0]| one register write, always ready
//
// A text byte is taken when valid and ready; its results sit in the output register the next cycle.
// A byte that needs a delimiter gives two beats and holds the input while the second beat waits.
// Otherwise one byte per cycle, with the input stalled only while a held beat waits.
// Reset clears the column and the gap flag, sets the line-start flag and empties the output register.
module byte_column_range_selector_top #(
  parameter int NUM_RANGES = bcrs_pkg::NumRangesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcrs_in_if.sink    in_i,
  bcrs_out_if.source out_o,
  bcrs_cfg_if.sink   cfg_i
);
  import bcrs_pkg::*;

  logic [ColW-1:0] range_lo [NUM_RANGES];
  logic [ColW-1:0] range_hi [NUM_RANGES];
  cfg_misc_t       misc;
  result_t         res;
  out_stat_t       stat;
  logic            in_ready;
  logic            in_fire;

  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;

  bcrs_cfg #(.NUM_RANGES(NUM_RANGES)) u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_i,
    .range_lo_o (range_lo),
    .range_hi_o (range_hi),
    .misc_o     (misc)
  );

  bcrs_select #(.NUM_RANGES(NUM_RANGES)) u_select (
    .clk_i,
    .rst_ni,
    .fire_i     (in_fire),
    .in_byte_i  (in_i.in_byte),
    .range_lo_i (range_lo),
    .range_hi_i (range_hi),
    .misc_i     (misc),
    .res_o      (res)
  );

  bcrs_out u_out (
    .clk_i,
    .rst_ni,
    .in_fire_i  (in_fire),
    .res_i      (res),
    .in_ready_o (in_ready),
    .stat_o     (stat),
    .out_o
  );

`ifndef SYNTHESIS
  a_extra_behind_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.extra_valid |-> stat.cur_valid)
    else $error("second beat held without a first beat");

  a_stall_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with no result pending");

  a_delim_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.extra_valid |-> !out_o.run_last)
    else $error("delimiter beat flagged as last");

  a_newline_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.in_byte == NewlineChr) |=> (out_o.valid && out_o.run_last))
    else $error("newline did not produce a terminator beat");
`endif

endmodule
